/* sv/hsv_pkg.sv */
`timescale 1ns / 1ps

package hsv_pkg;

  localparam int CH_W  = 8;
  localparam int QW    = 16;
  localparam int DIV_W = 11;
  localparam int PAD   = DIV_W - CH_W;
  localparam int NSTEP = QW;
  localparam logic [QW-1:0] SAT_ONE = QW'(32768);

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] dvs;
    logic [QW-1:0]    quo;
  } hsv_lane_t;

  typedef struct packed {
    hsv_lane_t       hue;
    hsv_lane_t       sat;
    logic            hue_zero;
    logic            sat_zero;
    logic [CH_W-1:0] value;
  } hsv_stage_t;

  // One restoring division step: the remainder stays below the divisor if it started below it.
  function automatic hsv_lane_t div_step(hsv_lane_t l);
    logic [DIV_W:0] wide;
    logic [DIV_W:0] dvs_w;
    hsv_lane_t      o;
    wide  = {l.rem, 1'b0};
    dvs_w = {1'b0, l.dvs};
    o     = l;
    if (wide >= dvs_w) begin
      o.rem = DIV_W'(wide - dvs_w);
      o.quo = {l.quo[QW-2:0], 1'b1};
    end else begin
      o.rem = wide[DIV_W-1:0];
      o.quo = {l.quo[QW-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

/* sv/hsv_front.sv */
`timescale 1ns / 1ps

module hsv_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic                        in_vld,
  input  logic [hsv_pkg::CH_W-1:0]    red,
  input  logic [hsv_pkg::CH_W-1:0]    green,
  input  logic [hsv_pkg::CH_W-1:0]    blue,
  output logic                        out_vld,
  output hsv_pkg::hsv_stage_t         out_stg
);

  logic [hsv_pkg::CH_W-1:0]  v;
  logic [hsv_pkg::CH_W-1:0]  mn;
  logic [hsv_pkg::DIV_W-1:0] r_w;
  logic [hsv_pkg::DIV_W-1:0] g_w;
  logic [hsv_pkg::DIV_W-1:0] b_w;
  logic [hsv_pkg::DIV_W-1:0] c_w;
  logic [hsv_pkg::DIV_W-1:0] dvs_h;
  logic [hsv_pkg::DIV_W-1:0] num;
  hsv_pkg::hsv_stage_t       stg_nxt;
  hsv_pkg::hsv_stage_t       stg_r;
  logic                      vld_r;

  always_comb begin
    v = (red > green) ? red : green;
    if (blue > v) begin
      v = blue;
    end
    mn = (red < green) ? red : green;
    if (blue < mn) begin
      mn = blue;
    end
    r_w   = {{hsv_pkg::PAD{1'b0}}, red};
    g_w   = {{hsv_pkg::PAD{1'b0}}, green};
    b_w   = {{hsv_pkg::PAD{1'b0}}, blue};
    c_w   = {{hsv_pkg::PAD{1'b0}}, v} - {{hsv_pkg::PAD{1'b0}}, mn};
    dvs_h = (c_w << 2) + (c_w << 1);
    if (v == red) begin
      if (green >= blue) begin
        num = g_w - b_w;
      end else begin
        num = dvs_h - (b_w - g_w);
      end
    end else if (v == green) begin
      num = (c_w << 1) + b_w - r_w;
    end else begin
      num = (c_w << 2) + r_w - g_w;
    end
    stg_nxt.hue.rem  = num;
    stg_nxt.hue.dvs  = dvs_h;
    stg_nxt.hue.quo  = '0;
    stg_nxt.sat.rem  = c_w;
    stg_nxt.sat.dvs  = {{(hsv_pkg::PAD - 1){1'b0}}, v, 1'b0};
    stg_nxt.sat.quo  = '0;
    stg_nxt.hue_zero = (v == mn);
    stg_nxt.sat_zero = (v == '0);
    stg_nxt.value    = v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stg_r <= stg_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_stg = stg_r;

endmodule

/* sv/hsv_div_step.sv */
`timescale 1ns / 1ps

module hsv_div_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic                in_vld,
  input  hsv_pkg::hsv_stage_t in_stg,
  output logic                out_vld,
  output hsv_pkg::hsv_stage_t out_stg
);

  hsv_pkg::hsv_stage_t stg_nxt;
  hsv_pkg::hsv_stage_t stg_r;
  logic                vld_r;

  always_comb begin
    stg_nxt     = in_stg;
    stg_nxt.hue = hsv_pkg::div_step(in_stg.hue);
    stg_nxt.sat = hsv_pkg::div_step(in_stg.sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stg_r <= stg_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_stg = stg_r;

endmodule

/* sv/rgb_to_hsv_pixel_converter.sv */
`timescale 1ns / 1ps
// Each accepted pixel passes the min/max stage and then every division stage.
// Throughput: one pixel per cycle; each of the 16 division stages after the
// min/max stage produces one quotient bit of hue and of saturation.
// The whole pipeline holds while a result is stalled on the output.
// Reset (synchronous, rst_n low) clears every stage valid bit.

module rgb_to_hsv_pixel_converter (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [hsv_pkg::CH_W-1:0] in_red,
  input  logic [hsv_pkg::CH_W-1:0] in_green,
  input  logic [hsv_pkg::CH_W-1:0] in_blue,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [hsv_pkg::QW-1:0]   out_hue,
  output logic [hsv_pkg::QW-1:0]   out_saturation,
  output logic [hsv_pkg::CH_W-1:0] out_value
);

  logic                advance;
  logic                vld [0:hsv_pkg::NSTEP];
  hsv_pkg::hsv_stage_t stg [0:hsv_pkg::NSTEP];
  hsv_pkg::hsv_stage_t last;

  assign advance  = !vld[hsv_pkg::NSTEP] || !out_stall;
  assign in_stall = !advance;

  hsv_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .in_vld  (in_valid),
    .red     (in_red),
    .green   (in_green),
    .blue    (in_blue),
    .out_vld (vld[0]),
    .out_stg (stg[0])
  );

  for (genvar k = 0; k < hsv_pkg::NSTEP; k++) begin : g_step
    hsv_div_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .in_vld  (vld[k]),
      .in_stg  (stg[k]),
      .out_vld (vld[k+1]),
      .out_stg (stg[k+1])
    );
  end

  assign last           = stg[hsv_pkg::NSTEP];
  assign out_valid      = vld[hsv_pkg::NSTEP];
  assign out_hue        = last.hue_zero ? '0 : last.hue.quo;
  assign out_saturation = last.sat_zero ? '0 : last.sat.quo;
  assign out_value      = last.value;

`ifndef SYNTHESIS
  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_saturation <= hsv_pkg::SAT_ONE)
    else $error("saturation above one");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_value == '0 |-> out_saturation == '0 && out_hue == '0)
    else $error("black pixel with non-zero hue or saturation");

  a_hue_rem: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last.hue_zero |-> last.hue.rem < last.hue.dvs)
    else $error("hue remainder not below divisor");

  a_sat_rem: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last.sat_zero |-> last.sat.rem < last.sat.dvs)
    else $error("saturation remainder not below divisor");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(last))
    else $error("pipeline moved during an output stall");
`endif

endmodule

/* tb/rgb_to_hsv_pixel_converter_test.sv */
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_converter_test;

  typedef logic [hsv_pkg::CH_W-1:0] channel_t;
  typedef logic [hsv_pkg::QW-1:0]   quant_t;

  typedef struct packed {
    quant_t   hue;
    quant_t   saturation;
    channel_t value;
  } hsv_pixel_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  channel_t in_red    = '0;
  channel_t in_green  = '0;
  channel_t in_blue   = '0;
  logic     out_stall = 1'b0;
  logic     in_stall;
  logic     out_valid;
  quant_t   out_hue;
  quant_t   out_saturation;
  channel_t out_value;

  hsv_pixel_t  expected_hsv[$];
  int unsigned mismatches = 0;
  bit          no_idle    = 1'b0;

  rgb_to_hsv_pixel_converter DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_value      (out_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic hsv_pixel_t convert_pixel(channel_t r, channel_t g, channel_t b);
    int unsigned v;
    int unsigned lo;
    int unsigned c;
    int unsigned num;
    hsv_pixel_t  px;
    v = r;
    if (g > v) v = g;
    if (b > v) v = b;
    lo = r;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    c = v - lo;
    px.value      = channel_t'(v);
    px.saturation = (v == 0) ? '0 : quant_t'((c * 32'd32768) / v);
    px.hue        = '0;
    if (c != 0) begin
      if (v == r) begin
        if (g >= b) num = g - b;
        else num = 6 * c - (b - g);
      end else if (v == g) begin
        num = 2 * c + b - r;
      end else begin
        num = 4 * c + r - g;
      end
      px.hue = quant_t'((num * 32'd65536) / (6 * c));
    end
    return px;
  endfunction

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    mismatches++;
  endtask

  task automatic send_pixel(channel_t r, channel_t g, channel_t b);
    int unsigned gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do @(posedge clk); while (in_stall);
    expected_hsv.push_back(convert_pixel(r, g, b));
  endtask

  always @(posedge clk) begin
    hsv_pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_hsv.size() == 0) begin
        report_mismatch("unexpected transaction (hue)", out_hue, 0);
      end else begin
        want = expected_hsv.pop_front();
        if (out_hue !== want.hue) report_mismatch("hue", out_hue, want.hue);
        if (out_saturation !== want.saturation)
          report_mismatch("saturation", out_saturation, want.saturation);
        if (out_value !== want.value) report_mismatch("value", out_value, want.value);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic test_corner_pixels();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd1, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd200, 8'd200, 8'd10);
    send_pixel(8'd10, 8'd200, 8'd200);
    send_pixel(8'd200, 8'd10, 8'd200);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd255);
    send_pixel(8'd170, 8'd85, 8'd0);
    send_pixel(8'd3, 8'd254, 8'd127);
  endtask

  task automatic test_random_pixels(int unsigned count);
    channel_t r;
    channel_t g;
    channel_t b;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      r = channel_t'($urandom);
      g = channel_t'($urandom);
      b = channel_t'($urandom);
      case ($urandom_range(0, 9))
        0: begin
          g = r;
          b = r;
        end
        1: g = r;
        2: b = g;
        3: b = r;
        4: begin
          g = r + 8'd1;
          b = r;
        end
        5: begin
          r = '1;
          b = '0;
        end
        6: g = '0;
        default: ;
      endcase
      send_pixel(r, g, b);
    end
  endtask

  task automatic test_streaming_pixels(int unsigned count);
    no_idle = 1'b1;
    for (int unsigned i = 0; i < count; i++) begin
      send_pixel(channel_t'($urandom), channel_t'($urandom), channel_t'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_corner_pixels();
    test_random_pixels(380);
    test_streaming_pixels(60);
    in_valid <= 1'b0;
    while (expected_hsv.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_hsv.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
